@@ hw/rtl/imuac_pkg.sv @@
// Shared types, constants and codes for the IMU activity classifier.
// No dependencies; every other RTL file of the block imports this package.

package imuac_pkg;

   // Sample and field widths
   localparam int SAMPLE_WIDTH = 16;                  // significant bits of each axis, 8..16
   localparam int FIELD_W      = 16;                  // width of each axis on the bus
   localparam int NUM_AXES     = 3;
   localparam int IN_FIELDS    = 2 * NUM_AXES;
   localparam int REQ_DATA_W   = IN_FIELDS * FIELD_W;

   // Square root datapath
   localparam int SUM_W  = 2 * SAMPLE_WIDTH;          // sum of three squares fits here
   localparam int REM_W  = SAMPLE_WIDTH + 2;          // partial remainder
   localparam int CNT_W  = $clog2(SAMPLE_WIDTH);      // step counter

   // Magnitudes and gravity estimate (unsigned Q16.8)
   localparam int MAG_W      = 16;
   localparam int FRAC_W     = 8;
   localparam int GRAV_W     = MAG_W + FRAC_W;
   localparam logic [GRAV_W-1:0] GRAV_RESET = GRAV_W'(8192 << FRAC_W);

   // Divide by ten: x * 0xCCCCCCCD >> 35, split in two 16-bit halves
   localparam int DIV_IN_W    = GRAV_W + 4;           // 9g + 256A + 5 stays below 2^28
   localparam int RECIP_W     = 16;
   localparam logic [RECIP_W-1:0] RECIP_HI = 16'hCCCC;
   localparam logic [RECIP_W-1:0] RECIP_LO = 16'hCCCD;
   localparam int RECIP_SHIFT = 35;
   localparam int PROD_W      = DIV_IN_W + RECIP_W;
   localparam int QSUM_W      = PROD_W + RECIP_W + 1;
   localparam int DIV_ROUND   = 5;

   // Configuration registers
   localparam int LIMIT_W   = 16;
   localparam int RATIO_W   = 11;
   localparam int CONFIRM_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int RATIO_SHIFT = 10;                   // flat ratio is Q1.10
   localparam int FLAT_W    = RATIO_W + MAG_W + 1;
   localparam int MAG_BIAS  = 8;

   // Result word layout
   localparam int CLASS_W    = 2;
   localparam int RSP_FIELDS_W = 2 * CLASS_W + 2 * MAG_W;
   localparam int RSP_DATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [CLASS_W-1:0] {
      POSTURE_STILL  = 2'd0,
      POSTURE_MOVING = 2'd1,
      POSTURE_FAST   = 2'd2
   } posture_type;

   typedef enum logic [2:0] {
      REG_STILL_ACCEL = 3'd0,
      REG_STILL_GYRO  = 3'd1,
      REG_FLAT_RATIO  = 3'd2,
      REG_RUN_ACCEL   = 3'd3,
      REG_RUN_GYRO    = 3'd4,
      REG_CONFIRM     = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [LIMIT_W-1:0]   still_accel_limit;
      logic [LIMIT_W-1:0]   still_gyro_limit;
      logic [RATIO_W-1:0]   flat_ratio;
      logic [LIMIT_W-1:0]   run_accel_limit;
      logic [LIMIT_W-1:0]   run_gyro_limit;
      logic [CONFIRM_W-1:0] confirm_count;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_SCALE,
      ST_DIV_LO,
      ST_DIV_HI,
      ST_DIV_SUM,
      ST_CLASS
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       load;
      logic       square;
      logic [1:0] axis;
      logic       root_step;
      logic       scale;
      logic       div_lo;
      logic       div_hi;
      logic       div_sum;
      logic       finish;
   } dp_cmd_type;

endpackage

@@ hw/rtl/imuac_regs.sv @@
// Configuration register file of the IMU activity classifier, APB-style access.
// Depends on imuac_pkg.

module imuac_regs
   import imuac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   // Write decode, masked to register width
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_STILL_ACCEL: cfg_in.still_accel_limit = csr_pwdata[LIMIT_W-1:0];
            REG_STILL_GYRO:  cfg_in.still_gyro_limit  = csr_pwdata[LIMIT_W-1:0];
            REG_FLAT_RATIO:  cfg_in.flat_ratio        = csr_pwdata[RATIO_W-1:0];
            REG_RUN_ACCEL:   cfg_in.run_accel_limit   = csr_pwdata[LIMIT_W-1:0];
            REG_RUN_GYRO:    cfg_in.run_gyro_limit    = csr_pwdata[LIMIT_W-1:0];
            REG_CONFIRM:     cfg_in.confirm_count     = csr_pwdata[CONFIRM_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.still_accel_limit <= LIMIT_W'(376);
         cfg_ff.still_gyro_limit  <= LIMIT_W'(1179);
         cfg_ff.flat_ratio        <= RATIO_W'(840);
         cfg_ff.run_accel_limit   <= LIMIT_W'(1837);
         cfg_ff.run_gyro_limit    <= LIMIT_W'(7860);
         cfg_ff.confirm_count     <= CONFIRM_W'(3);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      case (index)
         REG_STILL_ACCEL: csr_prdata = CSR_DATA_W'(cfg_ff.still_accel_limit);
         REG_STILL_GYRO:  csr_prdata = CSR_DATA_W'(cfg_ff.still_gyro_limit);
         REG_FLAT_RATIO:  csr_prdata = CSR_DATA_W'(cfg_ff.flat_ratio);
         REG_RUN_ACCEL:   csr_prdata = CSR_DATA_W'(cfg_ff.run_accel_limit);
         REG_RUN_GYRO:    csr_prdata = CSR_DATA_W'(cfg_ff.run_gyro_limit);
         REG_CONFIRM:     csr_prdata = CSR_DATA_W'(cfg_ff.confirm_count);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

@@ hw/rtl/imuac_ctrl.sv @@
// Sequencer of the IMU activity classifier: steps the datapath through
// squares, square roots, gravity update and classification. Depends on imuac_pkg.

module imuac_ctrl
   import imuac_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic       out_free,
   output dp_cmd_type cmd
);

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             last_axis;
   logic             last_root;

   assign last_axis = (cnt_ff == CNT_W'(NUM_AXES - 1));
   assign last_root = (cnt_ff == CNT_W'(SAMPLE_WIDTH - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_tvalid) state_in = ST_SQUARE;
         ST_SQUARE:  if (last_axis) state_in = ST_ROOT;
         ST_ROOT:    if (last_root) state_in = ST_SCALE;
         ST_SCALE:   state_in = ST_DIV_LO;
         ST_DIV_LO:  state_in = ST_DIV_HI;
         ST_DIV_HI:  state_in = ST_DIV_SUM;
         ST_DIV_SUM: state_in = ST_CLASS;
         ST_CLASS:   if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Step counter, shared by square and root phases
   always_comb begin
      cnt_in = cnt_ff;
      priority if (state_ff == ST_SQUARE && last_axis) begin
         cnt_in = '0;
      end else if (state_ff == ST_SQUARE || state_ff == ST_ROOT) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else begin
         cnt_in = '0;
      end
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      cmd.axis   = cnt_ff[1:0];
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SQUARE:  cmd.square    = 1'b1;
         ST_ROOT:    cmd.root_step = 1'b1;
         ST_SCALE:   cmd.scale     = 1'b1;
         ST_DIV_LO:  cmd.div_lo    = 1'b1;
         ST_DIV_HI:  cmd.div_hi    = 1'b1;
         ST_DIV_SUM: cmd.div_sum   = 1'b1;
         ST_CLASS:   cmd.finish    = out_free;
         default:    cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

@@ hw/rtl/imuac_dp.sv @@
// Datapath of the IMU activity classifier: squares, two radix-4 square roots,
// gravity filter with divide by ten, classifier, debounce and result register.
// Depends on imuac_pkg; driven by imuac_ctrl.

module imuac_dp
   import imuac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   input  cfg_type               cfg,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  out_free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   typedef struct packed {
      logic [REM_W-1:0]        rem;
      logic [SAMPLE_WIDTH-1:0] root;
   } root_type;

   // One radix-4 step of the floor square root
   function automatic root_type root_step(input logic [REM_W-1:0] rem,
                                          input logic [SAMPLE_WIDTH-1:0] root,
                                          input logic [1:0] pair);
      logic [REM_W+1:0] cand;
      logic [REM_W+1:0] trial;
      root_type         res;
      cand  = {rem, pair};
      trial = {2'b00, root, 2'b01};
      if (cand >= trial) begin
         res.rem  = REM_W'(cand - trial);
         res.root = {root[SAMPLE_WIDTH-2:0], 1'b1};
      end else begin
         res.rem  = REM_W'(cand);
         res.root = {root[SAMPLE_WIDTH-2:0], 1'b0};
      end
      return res;
   endfunction

   // Magnitude of the low SAMPLE_WIDTH bits taken as two's complement
   function automatic logic [SAMPLE_WIDTH-1:0] axis_abs(input logic [FIELD_W-1:0] f);
      logic [SAMPLE_WIDTH-1:0] v;
      v = f[SAMPLE_WIDTH-1:0];
      return v[SAMPLE_WIDTH-1] ? (~v + SAMPLE_WIDTH'(1)) : v;
   endfunction

   logic [SAMPLE_WIDTH-1:0] acc_abs_ff [NUM_AXES];
   logic [SAMPLE_WIDTH-1:0] gyr_abs_ff [NUM_AXES];
   logic [SUM_W-1:0]        asum_ff, gsum_ff;
   logic [REM_W-1:0]        arem_ff, grem_ff;
   logic [SAMPLE_WIDTH-1:0] aroot_ff, groot_ff;
   logic [DIV_IN_W-1:0]     div_in_ff;
   logic [FLAT_W-1:0]       flat_ff;
   logic [PROD_W-1:0]       prod_lo_ff, prod_hi_ff;
   logic [GRAV_W-1:0]       gravity_ff;
   posture_type             cand_ff, held_ff;
   logic [CONFIRM_W-1:0]    agree_ff;
   logic                    rsp_valid_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;

   logic [SAMPLE_WIDTH-1:0] acc_op, gyr_op;
   logic [SUM_W-1:0]        acc_sq, gyr_sq;
   root_type                aroot_in, groot_in;
   logic [MAG_W-1:0]        amag, gmag;
   logic [DIV_IN_W-1:0]     div_in_in;
   logic [FLAT_W-1:0]       flat_in;
   logic [RECIP_W-1:0]      recip;
   logic [PROD_W-1:0]       prod;
   logic [QSUM_W-1:0]       qsum;
   logic [GRAV_W-1:0]       a8, dev;
   logic [FLAT_W-1:0]       z_scaled;
   logic                    is_still, is_fast;
   posture_type             cls;
   posture_type             cand_in, held_in;
   logic [CONFIRM_W-1:0]    agree_in;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Axis select for the shared squarers
   always_comb begin
      case (cmd.axis)
         2'd0:    begin acc_op = acc_abs_ff[0]; gyr_op = gyr_abs_ff[0]; end
         2'd1:    begin acc_op = acc_abs_ff[1]; gyr_op = gyr_abs_ff[1]; end
         2'd2:    begin acc_op = acc_abs_ff[2]; gyr_op = gyr_abs_ff[2]; end
         default: begin acc_op = '0;            gyr_op = '0;            end
      endcase
   end

   assign acc_sq = SUM_W'(acc_op) * SUM_W'(acc_op);
   assign gyr_sq = SUM_W'(gyr_op) * SUM_W'(gyr_op);

   assign aroot_in = root_step(arem_ff, aroot_ff, asum_ff[SUM_W-1 -: 2]);
   assign groot_in = root_step(grem_ff, groot_ff, gsum_ff[SUM_W-1 -: 2]);

   assign amag = MAG_W'(aroot_ff);
   assign gmag = MAG_W'(groot_ff);

   // Gravity filter numerator: 9g + 256A + rounding
   assign div_in_in = (DIV_IN_W'(gravity_ff) << 3) + DIV_IN_W'(gravity_ff)
                      + DIV_IN_W'({amag, {FRAC_W{1'b0}}}) + DIV_IN_W'(DIV_ROUND);
   assign flat_in   = FLAT_W'(cfg.flat_ratio) * FLAT_W'({1'b0, amag} + (MAG_W+1)'(MAG_BIAS));

   // Shared reciprocal multiplier, one half per cycle
   assign recip = cmd.div_hi ? RECIP_HI : RECIP_LO;
   assign prod  = PROD_W'(div_in_ff) * PROD_W'(recip);
   assign qsum  = {1'b0, prod_hi_ff, {RECIP_W{1'b0}}} + QSUM_W'(prod_lo_ff);

   // Classification
   assign a8       = {amag, {FRAC_W{1'b0}}};
   assign dev      = (a8 >= gravity_ff) ? (a8 - gravity_ff) : (gravity_ff - a8);
   assign z_scaled = FLAT_W'({acc_abs_ff[2], {RATIO_SHIFT{1'b0}}});
   assign is_still = (dev < {cfg.still_accel_limit, {FRAC_W{1'b0}}})
                     && (gmag < cfg.still_gyro_limit) && (z_scaled > flat_ff);
   assign is_fast  = (dev > {cfg.run_accel_limit, {FRAC_W{1'b0}}})
                     || (gmag > cfg.run_gyro_limit);

   always_comb begin
      priority if (is_still) cls = POSTURE_STILL;
      else if (is_fast)      cls = POSTURE_FAST;
      else                   cls = POSTURE_MOVING;
   end

   // Debounce
   always_comb begin
      cand_in  = cand_ff;
      agree_in = agree_ff;
      if (cls == cand_ff) begin
         if (agree_ff < cfg.confirm_count) agree_in = agree_ff + CONFIRM_W'(1);
      end else begin
         cand_in  = cls;
         agree_in = CONFIRM_W'(1);
      end
      held_in = (agree_in >= cfg.confirm_count) ? cand_in : held_ff;
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            acc_abs_ff[i] <= axis_abs(req_tdata[i*FIELD_W +: FIELD_W]);
            gyr_abs_ff[i] <= axis_abs(req_tdata[(NUM_AXES+i)*FIELD_W +: FIELD_W]);
         end
         asum_ff  <= '0;
         gsum_ff  <= '0;
         arem_ff  <= '0;
         grem_ff  <= '0;
         aroot_ff <= '0;
         groot_ff <= '0;
      end
      if (cmd.square) begin
         asum_ff <= asum_ff + acc_sq;
         gsum_ff <= gsum_ff + gyr_sq;
      end
      if (cmd.root_step) begin
         asum_ff  <= asum_ff << 2;
         gsum_ff  <= gsum_ff << 2;
         arem_ff  <= aroot_in.rem;
         grem_ff  <= groot_in.rem;
         aroot_ff <= aroot_in.root;
         groot_ff <= groot_in.root;
      end
      if (cmd.scale) begin
         div_in_ff <= div_in_in;
         flat_ff   <= flat_in;
      end
      if (cmd.div_lo) prod_lo_ff <= prod;
      if (cmd.div_hi) prod_hi_ff <= prod;
      if (cmd.finish) begin
         rsp_data_ff <= RSP_DATA_W'({gravity_ff[GRAV_W-1:FRAC_W], amag, cls, held_in});
      end
   end

   // Block state and result handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff   <= GRAV_RESET;
         cand_ff      <= POSTURE_STILL;
         agree_ff     <= '0;
         held_ff      <= POSTURE_STILL;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.div_sum) gravity_ff <= qsum[RECIP_SHIFT +: GRAV_W];
         if (cmd.finish) begin
            cand_ff      <= cand_in;
            agree_ff     <= agree_in;
            held_ff      <= held_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

@@ hw/rtl/imu_activity_classifier_top.sv @@
// Top level of the IMU activity classifier: register file, sequencer, datapath.
// Depends on imuac_pkg, imuac_regs, imuac_ctrl and imuac_dp.

// One six-axis sample goes in per req word and one result word comes out for
// it. The block works on one sample at a time: after acceptance it forms the
// squares, runs the SAMPLE_WIDTH steps of the two radix-4 square roots side
// by side, then scales, runs the shared divide-by-ten multiplier, classifies
// and returns to idle to take the next sample. The square root iterations
// are the longest phase. A finished result waits in its own register, so
// the next sample is taken while it is still pending; only the classify
// step waits for that register to drain. Write the registers only
// while the block is idle.

module imu_activity_classifier_top
   import imuac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, 16 bits each, lowest first
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // stable_posture[1:0], detected_posture[3:2], accel_magnitude[19:4],
   // gravity_level[35:20], zero fill [39:36]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   dp_cmd_type cmd;
   logic       out_free;

   imuac_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   imuac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .out_free   (out_free),
      .cmd        (cmd)
   );

   imuac_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .req_tdata  (req_tdata),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ hw/rtl/imuac_checker.sv @@
// Port-level checks of the IMU activity classifier, bound to the top level.
// Depends on imuac_pkg and imu_activity_classifier_top.

module imuac_port_checks
   import imuac_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled result word keeps its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // One sample at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second sample taken while busy");

   // A new result comes only from the busy phase
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a sample in work");

   // Both class fields carry a defined posture
   a_class_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] <= POSTURE_FAST && rsp_tdata[3:2] <= POSTURE_FAST)
      else $error("undefined posture code");

endmodule

bind imu_activity_classifier_top imuac_port_checks u_imuac_port_checks (.*);
